[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the tag store RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// Condition in the same cycle implies the consequence.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication violated");

// Condition implies the consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle implication violated");

`endif

[hdl/rrct_pkg.sv]
// ----------------------------------------------------------------------------
// rrct_pkg
// Types, constants and helpers of the random replacement cache tag store.
// ----------------------------------------------------------------------------
`default_nettype none

package rrct_pkg;

   localparam int SLOTS      = 16;
   localparam int SLOT_W     = (SLOTS > 2) ? $clog2(SLOTS) : 1;
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int KEY_W      = 64;
   localparam int IDX_W      = 4;
   localparam int LFSR_W     = 16;

   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = 1;
   localparam int QCNT_W     = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_SEED_SEL = 1'b0;   // register select bit of the seed

   localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
   } qhead_type;

   typedef struct packed {
      logic              load;
      logic [LFSR_W-1:0] seed;
   } seed_cfg_type;

   // Fibonacci LFSR, taps 16,14,13,11, shifting right.
   function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
      logic fb;
      fb = v[0] ^ v[2] ^ v[3] ^ v[5];
      return {fb, v[LFSR_W-1:1]};
   endfunction

endpackage

`default_nettype wire

[hdl/random_replacement_cache_tags_core.sv]
// ----------------------------------------------------------------------------
// random_replacement_cache_tags_core
// Tag store of a fully associative cache with random (LFSR) replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_): one 64-bit lookup key per request, accepted when
//   req_valid is high and req_stall low. Result channel (rsp_): hit flag and
//   the slot that now holds the key, taken when rsp_valid is high and
//   rsp_stall low. Exactly one result per request, in request order.
//   Path: queue, then lookup into the result register. Throughput: one
//   request per cycle while the receiver does not stall, set by the tag
//   compare and slot update; with a slot count that is not a power of two,
//   a full miss holds further lookups while the modulo pipeline settles.
//   While the receiver stalls, hold the result register; the two-entry queue
//   keeps taking requests until it fills, then req_stall rises.
//   Reset: slot count clears to zero (store empty), the LFSR loads the reset
//   seed 44257, queue and result register empty. No clearing pass.
//   CSR: seed register at byte address 0; a write also loads the LFSR. Write
//   it only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module random_replacement_cache_tags_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [rrct_pkg::KEY_W-1:0]       req_lookup_key,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_hit,
   output logic [rrct_pkg::IDX_W-1:0]            rsp_slot_index,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [rrct_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [rrct_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rrct_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import rrct_pkg::*;

   logic [LFSR_W-1:0] seed_ff, seed_in;
   logic              seed_sel;
   logic              csr_wr;
   qhead_type         head;
   logic              pop;
   seed_cfg_type      seed_cfg;

   // CSR port: pready tied high, so no wait states; registers on 4-byte boundaries.
   assign csr_pready = 1'b1;
   assign seed_sel   = (csr_paddr[CSR_ADDR_W-1] == CSR_SEED_SEL);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      seed_in = seed_ff;
      if (csr_wr && seed_sel) begin
         seed_in = csr_pwdata[LFSR_W-1:0];
      end
      csr_prdata = '0;
      if (seed_sel) begin
         csr_prdata = {{(CSR_DATA_W - LFSR_W){1'b0}}, seed_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   // Load the LFSR in the same edge as the seed register.
   assign seed_cfg.load = csr_wr && seed_sel;
   assign seed_cfg.seed = csr_pwdata[LFSR_W-1:0];

   // Front: accept and queue requests.
   rrct_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_lookup_key (req_lookup_key),
      .head           (head),
      .pop            (pop)
   );

   // Back: look up, fill or replace, drive the result register.
   rrct_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .seed_cfg       (seed_cfg),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_slot_index (rsp_slot_index)
   );

endmodule

`default_nettype wire

[hdl/rrct_front.sv]
// ----------------------------------------------------------------------------
// rrct_front
// Request intake: a short key queue between the request port and the tag store.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rrct_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [rrct_pkg::KEY_W-1:0] req_lookup_key,
   output rrct_pkg::qhead_type            head,
   input  wire logic                      pop
);
   import rrct_pkg::*;

   logic [KEY_W-1:0]  mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              push;

   assign req_stall = (cnt_ff == QCNT_W'(QDEPTH));
   assign push      = req_valid && !req_stall;

   assign head.valid = (cnt_ff != '0);
   assign head.key   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_lookup_key;
      end
   end

   `ASSERT_ALWAYS(a_q_bound, clock, reset, cnt_ff <= QCNT_W'(QDEPTH))
   `ASSERT_IMPLIES(a_pop_nonempty, clock, reset, pop, cnt_ff != '0)

endmodule

`default_nettype wire

[hdl/rrct_back.sv]
// ----------------------------------------------------------------------------
// rrct_back
// Tag store: parallel lookup, in-order fill, LFSR victim replacement, result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rrct_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rrct_pkg::qhead_type         head,
   output logic                             pop,
   input  wire rrct_pkg::seed_cfg_type      seed_cfg,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_hit,
   output logic [rrct_pkg::IDX_W-1:0]       rsp_slot_index
);
   import rrct_pkg::*;

   logic [KEY_W-1:0]  key_ff [SLOTS];
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [LFSR_W-1:0] lfsr_ff, lfsr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff;
   logic [IDX_W-1:0]  rsp_slot_ff;

   logic [SLOTS-1:0]  match;
   logic              hit;
   logic [SLOT_W-1:0] hit_idx;
   logic [SLOT_W-1:0] new_slot;
   logic [SLOT_W-1:0] res_slot;
   logic [IDX_W-1:0]  res_idx;
   logic [SLOT_W-1:0] victim;
   logic              victim_ok;
   logic              full;
   logic              out_free;
   logic              fill_miss;
   logic              lfsr_step;

   // Victim = LFSR mod SLOTS.
   if ((SLOTS & (SLOTS - 1)) == 0) begin : g_vic_mask
      assign victim    = lfsr_ff[SLOT_W-1:0];
      assign victim_ok = 1'b1;
   end else begin : g_vic_recip
      localparam longint unsigned RECIP_L = ((64'd1 << 32) + SLOTS - 1) / SLOTS;
      localparam logic [31:0]     RECIP   = RECIP_L[31:0];
      logic [47:0]       prod_ff;
      logic [LFSR_W-1:0] lfsr_d_ff;
      logic [SLOT_W-1:0] rem_ff;
      logic [1:0]        wait_ff, wait_in;
      logic [LFSR_W-1:0] qn;
      logic [LFSR_W-1:0] rem_full;

      assign qn       = LFSR_W'(prod_ff[47:32] * LFSR_W'(SLOTS));
      assign rem_full = lfsr_d_ff - qn;

      always_comb begin
         wait_in = wait_ff;
         if (seed_cfg.load || lfsr_step) begin
            wait_in = 2'd2;
         end else if (wait_ff != 2'd0) begin
            wait_in = wait_ff - 2'd1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            wait_ff <= 2'd2;
         end else begin
            wait_ff <= wait_in;
         end
      end

      always_ff @(posedge clock) begin
         prod_ff   <= 48'(lfsr_ff) * 48'(RECIP);
         lfsr_d_ff <= lfsr_ff;
         rem_ff    <= rem_full[SLOT_W-1:0];
      end

      assign victim    = rem_ff;
      assign victim_ok = (wait_ff == 2'd0);
   end

   // Result slot to the 4-bit output field.
   if (SLOT_W >= IDX_W) begin : g_idx_cut
      assign res_idx = res_slot[IDX_W-1:0];
   end else begin : g_idx_ext
      assign res_idx = {{(IDX_W - SLOT_W){1'b0}}, res_slot};
   end

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         match[i] = (key_ff[i] == head.key) && (CNT_W'(i) < fill_ff);
         if (match[i]) begin
            hit_idx = hit_idx | SLOT_W'(i);
         end
      end
   end

   assign hit       = |match;
   assign full      = (fill_ff == CNT_W'(SLOTS));
   assign new_slot  = full ? victim : fill_ff[SLOT_W-1:0];
   assign res_slot  = hit ? hit_idx : new_slot;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = head.valid && out_free && victim_ok;
   assign fill_miss = pop && !hit && !full;
   assign lfsr_step = pop && !hit && full;

   always_comb begin
      fill_in      = fill_miss ? fill_ff + 1'b1 : fill_ff;
      lfsr_in      = lfsr_ff;
      if (seed_cfg.load) begin
         lfsr_in = seed_cfg.seed;
      end else if (lfsr_step) begin
         lfsr_in = lfsr_next(lfsr_ff);
      end
      rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         lfsr_ff      <= SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && !hit) begin
         key_ff[new_slot] <= head.key;
      end
      if (pop) begin
         rsp_hit_ff  <= hit;
         rsp_slot_ff <= res_idx;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_slot_index = rsp_slot_ff;

   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= CNT_W'(SLOTS))
   `ASSERT_IMPLIES(a_single_match, clock, reset, head.valid, $onehot0(match))
   `ASSERT_NEXT(a_fill_rise, clock, reset, fill_miss, fill_ff == ($past(fill_ff) + 1'b1))

endmodule

`default_nettype wire

[tb/random_replacement_cache_tags_core_tb.sv]
// ----------------------------------------------------------------------------
// random_replacement_cache_tags_core_tb
// Self-checking bench of the random replacement cache tag store: directed
// fills, hits and full misses, then random lookups over several seeds and
// idle/stall patterns, each result checked against a cycle-free predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module random_replacement_cache_tags_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_W  = rrct_pkg::KEY_W;
   localparam int IDX_W  = rrct_pkg::IDX_W;
   localparam int LFSR_W = rrct_pkg::LFSR_W;
   localparam int ADDR_W = rrct_pkg::CSR_ADDR_W;
   localparam int DATA_W = rrct_pkg::CSR_DATA_W;

   // Register map: the seed is register 0, index 1 decodes to nothing.
   localparam logic [ADDR_W-1:0] SEED_ADDR  = 3'd0;
   localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;

   localparam int PHASES          = 6;
   localparam int PHASE_REQUESTS  = 240;
   localparam int LONG_HOLD       = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int RECENT_DEPTH    = 32;
   localparam longint RUN_LIMIT_NS = 2_000_000;

   // -------------------------------------------------------------------------
   // Scoreboard: mirrors the tag store and queues the outcome of each request
   // -------------------------------------------------------------------------
   class tag_lookup_scoreboard;
      typedef struct packed {
         logic             hit;
         logic [IDX_W-1:0] slot;
      } outcome_type;

      logic [KEY_W-1:0]  slot_key [rrct_pkg::SLOTS];
      int unsigned       fill;
      logic [LFSR_W-1:0] victim_lfsr;
      outcome_type       pending [$];
      int unsigned       mismatches;

      function new();
         fill        = 0;
         victim_lfsr = rrct_pkg::SEED_RESET;
         mismatches  = 0;
      endfunction

      function void load_seed(input logic [LFSR_W-1:0] seed);
         victim_lfsr = seed;
      endfunction

      // Work out hit/slot for an accepted request and update the mirror.
      function void note_lookup(input logic [KEY_W-1:0] key);
         outcome_type res;
         int unsigned idx;
         bit          found;
         found = 1'b0;
         idx   = 0;
         for (int i = 0; i < fill; i++) begin
            if (!found && slot_key[i] == key) begin
               found = 1'b1;
               idx   = i;
            end
         end
         if (!found) begin
            if (fill < rrct_pkg::SLOTS) begin
               idx = fill;
               fill++;
            end else begin
               idx = victim_lfsr % rrct_pkg::SLOTS;
               victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^
                              victim_lfsr[5], victim_lfsr[LFSR_W-1:1]};
            end
            slot_key[idx] = key;
         end
         res.hit  = found;
         res.slot = idx[IDX_W-1:0];
         pending.push_back(res);
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      task check_outcome(input logic hit, input logic [IDX_W-1:0] slot);
         outcome_type want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result hit=%0b slot=%0d", hit, slot));
         end else begin
            want = pending.pop_front();
            if (hit !== want.hit)
               report_mismatch($sformatf("hit %0b, want %0b", hit, want.hit));
            if (slot !== want.slot)
               report_mismatch($sformatf("slot %0d, want %0d", slot, want.slot));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block under test
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2;
      clock = 1'b1;
      #2;
      clock = 1'b0;
   end

   logic              req_valid;
   logic              req_stall;
   logic [KEY_W-1:0]  req_lookup_key;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_hit;
   logic [IDX_W-1:0]  rsp_slot_index;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   random_replacement_cache_tags_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_lookup_key (req_lookup_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_slot_index (rsp_slot_index),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   tag_lookup_scoreboard book = new();

   // Idle/stall odds in percent, set per phase by the stimulus process.
   int unsigned req_idle_pct  = 0;
   int unsigned rsp_stall_pct = 0;

   // Long receiver hold: armed by the stimulus, counted by the receiver.
   logic        hold_armed = 1'b0;
   bit          hold_used  = 1'b0;
   int unsigned hold_left  = 0;

   logic [KEY_W-1:0] recent_keys [$];

   // -------------------------------------------------------------------------
   // Request side. All tasks start and end right after a rising edge; values
   // read there are the ones the block saw at that edge.
   // -------------------------------------------------------------------------
   task automatic send_request(input logic [KEY_W-1:0] key);
      // Idle a random number of cycles, then offer and hold until taken.
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_lookup_key <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_lookup(key);
      recent_keys.push_back(key);
      if (recent_keys.size() > RECENT_DEPTH) recent_keys.pop_front();
   endtask

   task automatic csr_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Hold until every queued outcome has come back.
   task automatic wait_drained();
      while (book.pending.size() != 0) @(posedge clock);
   endtask

   // Seed write, a write to the unused index, then read the seed back.
   task automatic load_seed(input logic [LFSR_W-1:0] seed);
      logic [DATA_W-1:0] rd;
      csr_write(SEED_ADDR, {16'($urandom), seed});
      book.load_seed(seed);
      csr_write(SPARE_ADDR, $urandom);
      csr_read(SEED_ADDR, rd);
      if (rd[LFSR_W-1:0] !== seed)
         book.report_mismatch($sformatf("seed reads %h, want %h", rd[LFSR_W-1:0], seed));
   endtask

   // Random key mix: resident keys (hits) most often, some recent keys that may
   // have been evicted, some extremes, and fresh random keys (misses).
   function automatic logic [KEY_W-1:0] pick_lookup_key();
      int unsigned roll;
      logic [KEY_W-1:0] one_hot;
      roll    = $urandom_range(99);
      one_hot = 64'h1 << $urandom_range(KEY_W - 1);
      if (roll < 45 && book.fill > 0)
         return book.slot_key[$urandom_range(book.fill - 1)];
      if (roll < 60 && recent_keys.size() > 0)
         return recent_keys[$urandom_range(recent_keys.size() - 1)];
      if (roll < 70) begin
         case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return one_hot;
            default: return ~one_hot;
         endcase
      end
      return {$urandom, $urandom};
   endfunction

   // -------------------------------------------------------------------------
   // Result side: check each taken result, then pick the next stall value.
   // -------------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall)
            book.check_outcome(rsp_hit, rsp_slot_index);
         // Start the long hold once, so the queue fills and req_stall rises.
         if (hold_armed && !hold_used) begin
            hold_used = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      logic [KEY_W-1:0]  last_fill_key;
      logic [LFSR_W-1:0] seed;

      req_valid      = 1'b0;
      req_lookup_key = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fill in order, hit on extremes, hit first and last slot,
      // then miss with the store full so the reset seed picks victims.
      send_request(64'h0);
      send_request('1);
      send_request(64'h0);
      send_request(64'h8000_0000_0000_0000);
      send_request(64'h1);
      send_request(64'h5555_5555_5555_5555);
      send_request(64'hAAAA_AAAA_AAAA_AAAA);
      send_request('1);
      last_fill_key = '0;
      for (int i = 0; i < 10; i++) begin
         last_fill_key = {32'h0F0F_F0F0, 28'h0, 4'(i)} ^ {4'(i), 60'h0};
         send_request(last_fill_key);
      end
      send_request(64'h0);
      send_request(last_fill_key);
      send_request(64'hDEAD_BEEF_0000_0001);
      send_request(64'hDEAD_BEEF_0000_0002);
      send_request('1);
      req_valid <= 1'b0;
      wait_drained();

      // Random phases, each under its own seed and idle pattern. Seeds cover
      // the lowest and highest values, zero (victim always slot 0), the reset
      // value and random ones.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: seed = 16'h0001;
            1: seed = 16'hFFFF;
            2: seed = 16'h0000;
            4: seed = rrct_pkg::SEED_RESET;
            default: seed = 16'($urandom_range(1, 65535));
         endcase
         load_seed(seed);

         case (p)
            1: begin
               req_idle_pct  = 58;
               rsp_stall_pct = 0;
            end
            2, 4: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 58;
            end
            3: begin
               req_idle_pct  = 22;
               rsp_stall_pct = 22;
            end
            default: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         // Back-pressure the block hard in one phase while requests keep coming.
         if (p == 4) hold_armed <= 1'b1;

         for (int n = 0; n < PHASE_REQUESTS; n++)
            send_request(pick_lookup_key());
         req_valid <= 1'b0;
         wait_drained();
      end

      // Drain, allow a few more cycles for stray results, then conclude.
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.pending.size() != 0)
         book.report_mismatch($sformatf("%0d results never came", book.pending.size()));
      if (book.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Safety net against a hung handshake.
   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

[random_replacement_cache_tags_core.f]
+incdir+hdl
hdl/rrct_pkg.sv
hdl/rrct_front.sv
hdl/rrct_back.sv
hdl/random_replacement_cache_tags_core.sv
tb/random_replacement_cache_tags_core_tb.sv
